// ----- design/mandelbrot_escape_time_macros.svh -----
// Assertion macros shared by the block. They sample on clk and are
// disabled while rst is high, so the module that uses them must have both.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MBE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mandelbrot_escape_time: assertion failed");

// Next-cycle implication.
`define MBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mandelbrot_escape_time: assertion failed");

`else

`define MBE_ASSERT_IMPL(label, ante, cons)
`define MBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/mbe_pkg.sv -----
`default_nettype none

package mbe_pkg;

  // Field and register widths
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int SCALE_W    = 31;
  localparam int CENTER_W   = 30;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Fixed-point formats
  localparam int FRAC_BITS = 28;
  localparam int Q_W       = 32;   // Q4.28 c value
  localparam int Z_W       = 31;   // committed z component, |z| <= 2.0
  localparam int ZP_W      = 2 * Z_W;  // product of two z components
  localparam int SQ_W      = 59;   // square of committed z, <= 2^58
  localparam int SQS_W     = SQ_W + 1;
  localparam int STEP_W    = 33;   // candidate z before the range test

  // Pixel to plane mapping
  localparam int OFF_W      = DIM_W + 1;          // 2*pixel - span, signed
  localparam int PROD_W     = OFF_W + SCALE_W + 1;
  localparam int MAG_W      = 44;                 // |offset * scale| < 2^44
  localparam int DEN_W      = DIM_W + 1;          // 2 * height
  localparam int QS_W       = MAG_W + 1;
  localparam int SUM_W      = QS_W + 1;
  localparam int DIV_CNT_W  = $clog2(MAG_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

  // Constants
  localparam logic signed [SUM_W-1:0]  Q428_MAX  = 46'sd2147483647;
  localparam logic signed [SUM_W-1:0]  Q428_MIN  = -46'sd2147483648;
  localparam logic signed [STEP_W-1:0] TWO_STEP  = 33'sd536870912;
  localparam logic signed [Z_W-1:0]    TWO_Z     = 31'sd536870912;
  localparam logic [SQS_W-1:0]         FOUR_Q856 = 60'd288230376151711744;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  // Register reset values
  localparam logic [SCALE_W-1:0]         SCALE_RST        = 31'd536870912;
  localparam logic signed [CENTER_W-1:0] CENTER_X_RST     = -30'sd134217728;
  localparam logic signed [CENTER_W-1:0] CENTER_Y_RST     = 30'sd0;
  localparam logic [DIM_W-1:0]           IMAGE_WIDTH_RST  = 13'd960;
  localparam logic [DIM_W-1:0]           IMAGE_HEIGHT_RST = 13'd600;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAPMUL,
    ST_DIV,
    ST_MAPFIN,
    ST_MUL,
    ST_STEP,
    ST_OUT
  } mbe_state_t;

endpackage

`default_nettype wire

// ----- design/mbe_if.sv -----
`default_nettype none

// Pixel coordinate channel
interface mbe_pixel_if import mbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// Escape-time result channel
interface mbe_result_if import mbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic               inside_set;

  modport source (output valid, output iteration_count, output inside_set, input ready);
  modport sink (input valid, input iteration_count, input inside_set, output ready);
endinterface

`default_nettype wire

// ----- design/mandelbrot_escape_time.sv -----
// Channel   Dir  Payload                          Handshake
// pixel     in   pixel_x[11:0], pixel_y[11:0]     valid/ready
// result    out  iteration_count[8:0], inside_set valid/ready
// config    in   reg_index[2:0], write_data[30:0] write_enable, no stall
//
// One pixel at a time. Mapping runs the shared restoring divider once for
// each coordinate; it retires one quotient bit per cycle.
// Each escape-time step then multiplies, then adds and tests.
// rst is synchronous; it restores the view registers and empties the block.
// A waiting result sits in the output register; the next pixel is taken
// meanwhile and holds only at its own end if that register is still full.
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int MAX_ITERATIONS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  mbe_pixel_if.sink             pixel,
  mbe_result_if.source          result
);

  localparam int CNT_W = ($clog2(MAX_ITERATIONS + 1) > COUNT_W) ?
                         $clog2(MAX_ITERATIONS + 1) : COUNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITERATIONS);

  // View registers
  logic [SCALE_W-1:0]         scale;
  logic signed [CENTER_W-1:0] mid_re;
  logic signed [CENTER_W-1:0] mid_im;
  logic [DIM_W-1:0]           image_width;
  logic [DIM_W-1:0]           image_height;

  // Sequencer
  mbe_state_t state, state_next;

  // Mapping datapath
  logic [PIX_W-1:0]     px, py;
  logic                 coord_sel;
  logic                 num_neg;
  logic [MAG_W-1:0]     div_work;
  logic [DEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [Q_W-1:0] cx, cy;

  // Iteration datapath
  logic signed [Z_W-1:0]  x, y;
  logic signed [ZP_W-1:0] xx, yy, xy;
  logic                   cand;
  logic [CNT_W-1:0]       count;
  logic                   in_set;

  // Output register
  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               res_inside;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= SCALE_RST;
      mid_re       <= CENTER_X_RST;
      mid_im       <= CENTER_Y_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_SCALE:        scale        <= write_data[SCALE_W-1:0];
        REG_CENTER_X:     mid_re       <= write_data[CENTER_W-1:0];
        REG_CENTER_Y:     mid_im       <= write_data[CENTER_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= write_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= write_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Mapping: offset * scale, then sign and magnitude for the divider
  logic [DIM_W-1:0]          height_eff;
  logic [DEN_W-1:0]          den;
  logic [PIX_W-1:0]          pix_sel;
  logic [DIM_W-1:0]          span_sel;
  logic signed [OFF_W-1:0]   offset;
  logic signed [PROD_W-1:0]  map_prod;
  logic signed [PROD_W-1:0]  map_mag;

  assign height_eff = (image_height == '0) ? DIM_W'(1) : image_height;
  assign den        = {height_eff, 1'b0};
  assign pix_sel    = coord_sel ? py : px;
  assign span_sel   = coord_sel ? height_eff : image_width;
  assign offset     = $signed({1'b0, pix_sel, 1'b0}) - $signed({1'b0, span_sel});
  assign map_prod   = offset * $signed({1'b0, scale});
  assign map_mag    = map_prod[PROD_W-1] ? -map_prod : map_prod;

  // Divider step: one quotient bit per cycle
  logic [DEN_W:0] trial;
  logic           trial_ge;

  assign trial    = {rem, div_work[MAG_W-1]};
  assign trial_ge = (trial >= {1'b0, den});

  // Quotient sign, center offset and saturation
  logic signed [QS_W-1:0]     q_mag;
  logic signed [QS_W-1:0]     q_signed;
  logic signed [CENTER_W-1:0] center_sel;
  logic signed [SUM_W-1:0]    map_sum;
  logic signed [Q_W-1:0]      map_sat;

  assign q_mag      = $signed({1'b0, div_work});
  assign q_signed   = num_neg ? -q_mag : q_mag;
  assign center_sel = coord_sel ? mid_im : mid_re;
  assign map_sum    = SUM_W'(q_signed) + SUM_W'(center_sel);

  always_comb begin
    priority if (map_sum > Q428_MAX) begin
      map_sat = Q428_MAX[Q_W-1:0];
    end else if (map_sum < Q428_MIN) begin
      map_sat = Q428_MIN[Q_W-1:0];
    end else begin
      map_sat = map_sum[Q_W-1:0];
    end
  end

  // Step: magnitude test of the held candidate and the next candidate
  logic [SQS_W-1:0]         sq_sum;
  logic                     escape_mag;
  logic [CNT_W-1:0]         count_commit;
  logic                     hit_limit;
  logic signed [ZP_W-1:0]   diff;
  logic signed [ZP_W-1:0]   re_sh;
  logic signed [ZP_W-1:0]   im_sh;
  logic signed [STEP_W-1:0] nx, ny;
  logic                     escape_bound;
  logic                     finish;

  assign sq_sum       = SQS_W'(xx[SQ_W-1:0]) + SQS_W'(yy[SQ_W-1:0]);
  assign escape_mag   = cand && (sq_sum > FOUR_Q856);
  assign count_commit = count + CNT_W'(cand);
  assign hit_limit    = (count_commit == CNT_MAX);
  assign diff         = xx - yy;
  assign re_sh        = diff >>> FRAC_BITS;
  assign im_sh        = xy >>> (FRAC_BITS - 1);   // 2xy / 2^28
  assign nx           = STEP_W'(re_sh) + STEP_W'(cx);
  assign ny           = STEP_W'(im_sh) + STEP_W'(cy);
  assign escape_bound = (nx > TWO_STEP) || (nx < -TWO_STEP) ||
                        (ny > TWO_STEP) || (ny < -TWO_STEP);
  assign finish       = escape_mag || hit_limit || escape_bound;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (pixel.valid) state_next = ST_MAPMUL;
      ST_MAPMUL: state_next = ST_DIV;
      ST_DIV:    if (div_cnt == DIV_LAST) state_next = ST_MAPFIN;
      ST_MAPFIN: state_next = coord_sel ? ST_MUL : ST_MAPMUL;
      ST_MUL:    state_next = ST_STEP;
      ST_STEP:   state_next = finish ? ST_OUT : ST_MUL;
      ST_OUT:    if (!res_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic res_load;

  always_comb begin
    pixel.ready = (state == ST_IDLE);
    res_load    = (state == ST_OUT) && (!res_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        px        <= pixel.pixel_x;
        py        <= pixel.pixel_y;
        coord_sel <= 1'b0;
      end
      ST_MAPMUL: begin
        num_neg  <= map_prod[PROD_W-1];
        div_work <= map_mag[MAG_W-1:0];
        rem      <= '0;
        div_cnt  <= '0;
      end
      ST_DIV: begin
        rem      <= trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        div_work <= {div_work[MAG_W-2:0], trial_ge};
        div_cnt  <= div_cnt + DIV_CNT_W'(1);
      end
      ST_MAPFIN: begin
        if (coord_sel) begin
          cy    <= map_sat;
          x     <= '0;
          y     <= '0;
          cand  <= 1'b0;
          count <= '0;
        end else begin
          cx <= map_sat;
        end
        coord_sel <= 1'b1;
      end
      ST_MUL: begin
        xx <= x * x;
        yy <= y * y;
        xy <= x * y;
      end
      ST_STEP: begin
        if (!escape_mag) begin
          count <= count_commit;
        end
        in_set <= !escape_mag && hit_limit;
        x      <= nx[Z_W-1:0];
        y      <= ny[Z_W-1:0];
        cand   <= 1'b1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count  <= count[COUNT_W-1:0];
      res_inside <= in_set;
    end
  end

  assign result.valid           = res_valid;
  assign result.iteration_count = res_count;
  assign result.inside_set      = res_inside;

  // Checks
`include "mandelbrot_escape_time_macros.svh"

  `MBE_ASSERT_NEXT(a_accept_starts_x, pixel.valid && pixel.ready, (state == ST_MAPMUL) && !coord_sel)
  `MBE_ASSERT_IMPL(a_fin_after_div, state == ST_MAPFIN, $past(state) == ST_DIV)
  `MBE_ASSERT_IMPL(a_z_in_disk, state == ST_MUL, (x <= TWO_Z) && (x >= -TWO_Z) && (y <= TWO_Z) && (y >= -TWO_Z))
  `MBE_ASSERT_IMPL(a_count_below_limit, state == ST_STEP, count < CNT_MAX)
  `MBE_ASSERT_IMPL(a_inside_full_count, result.valid && result.inside_set, result.iteration_count == CNT_MAX[COUNT_W-1:0])

endmodule

`default_nettype wire

// ----- tb/mandelbrot_escape_time_tb.sv -----
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb import mbe_pkg::*;;

  localparam int     MAX_ITERATIONS = 256;
  localparam longint CYCLE_LIMIT    = 5000000;
  localparam int     DRAIN_CYCLES   = 700;
  localparam longint TWO_FIX        = longint'(1) << 29;
  localparam longint FOUR_FIX_SQ    = longint'(1) << 58;
  localparam longint FIX_MAX        = 64'sd2147483647;
  localparam longint FIX_MIN        = -64'sd2147483648;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               in_set;
  } escape_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  mbe_pixel_if  pixel_ch ();
  mbe_result_if result_ch ();

  mandelbrot_escape_time #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .pixel       (pixel_ch),
    .result      (result_ch)
  );

  // View registers as the block should hold them
  logic [SCALE_W-1:0]         view_scale;
  logic signed [CENTER_W-1:0] view_cx;
  logic signed [CENTER_W-1:0] view_cy;
  logic [DIM_W-1:0]           view_w;
  logic [DIM_W-1:0]           view_h;

  pixel_t  pending_pixels[$];
  escape_t expected_escapes[$];
  int      pixels_in_flight;
  int      error_count;
  longint  cycle_count;
  logic    pix_taken;
  logic    steady;
  int      burst_left;
  int      gap_left;
  int      stall_left;

  always #10 clk = ~clk;

  // Pixel to plane coordinate, Q4.28, saturated
  function automatic longint plane_coord(input longint pix, input longint span,
                                         input longint center, input longint height);
    longint num;
    longint v;
    num = (2 * pix - span) * longint'(view_scale);
    v = num / (2 * height) + center;
    if (v > FIX_MAX) v = FIX_MAX;
    if (v < FIX_MIN) v = FIX_MIN;
    return v;
  endfunction

  // Escape-time count for one pixel under the current view
  function automatic escape_t escape_time(input logic [PIX_W-1:0] px,
                                          input logic [PIX_W-1:0] py);
    longint  h;
    longint  cx;
    longint  cy;
    longint  zx;
    longint  zy;
    longint  nx;
    longint  ny;
    int      steps;
    escape_t res;
    h = (view_h == '0) ? 1 : longint'(view_h);
    cx = plane_coord(longint'(px), longint'(view_w), longint'(view_cx), h);
    cy = plane_coord(longint'(py), h, longint'(view_cy), h);
    zx = 0;
    zy = 0;
    steps = 0;
    while (steps < MAX_ITERATIONS) begin
      nx = ((zx * zx - zy * zy) >>> FRAC_BITS) + cx;
      ny = ((2 * zx * zy) >>> FRAC_BITS) + cy;
      if ((nx < 0 ? -nx : nx) > TWO_FIX || (ny < 0 ? -ny : ny) > TWO_FIX) break;
      if (nx * nx + ny * ny > FOUR_FIX_SQ) break;
      zx = nx;
      zy = ny;
      steps++;
    end
    res.count = steps[COUNT_W-1:0];
    res.in_set = (steps == MAX_ITERATIONS);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic queue_pixel(input int px, input int py);
    pixel_t p;
    p.x = px[PIX_W-1:0];
    p.y = py[PIX_W-1:0];
    pending_pixels.push_back(p);
    pixels_in_flight++;
  endtask

  task automatic wait_idle();
    while (pixels_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_view_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    case (idx)
      REG_SCALE:        view_scale = data[SCALE_W-1:0];
      REG_CENTER_X:     view_cx = data[CENTER_W-1:0];
      REG_CENTER_Y:     view_cy = data[CENTER_W-1:0];
      REG_IMAGE_WIDTH:  view_w = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT: view_h = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // New view, written only once the block has drained
  task automatic set_view(input logic [SCALE_W-1:0] sc, input logic [CFG_DATA_W-1:0] cxd,
                          input logic [CFG_DATA_W-1:0] cyd, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h);
    wait_idle();
    write_view_reg(REG_SCALE, CFG_DATA_W'(sc));
    write_view_reg(REG_CENTER_X, cxd);
    write_view_reg(REG_CENTER_Y, cyd);
    write_view_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_view_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // Cycle count, steady mode, item acceptance and result checking
  always @(posedge clk) begin
    escape_t exp_res;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("mandelbrot_escape_time_tb: errors");
      $finish;
    end else begin
      if (cycle_count % 2048 == 0) steady <= ($urandom_range(0, 3) == 0);
      if (!rst) begin
        if (pixel_ch.valid && pixel_ch.ready) begin
          expected_escapes.push_back(escape_time(pixel_ch.pixel_x, pixel_ch.pixel_y));
          pix_taken <= 1'b1;
        end
        if (result_ch.valid && result_ch.ready) begin
          if (expected_escapes.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (count %0d)",
                                      result_ch.iteration_count));
          end else begin
            exp_res = expected_escapes.pop_front();
            pixels_in_flight--;
            if (result_ch.iteration_count !== exp_res.count)
              report_mismatch($sformatf("iteration_count got %0d exp %0d",
                                        result_ch.iteration_count, exp_res.count));
            if (result_ch.inside_set !== exp_res.in_set)
              report_mismatch($sformatf("inside_set got %0b exp %0b",
                                        result_ch.inside_set, exp_res.in_set));
          end
        end
      end
    end
  end

  // Pixel driver: bursts of items with gaps between them
  always @(negedge clk) begin
    pixel_t p;
    if (!rst && (!pixel_ch.valid || pix_taken)) begin
      if (gap_left != 0 && !steady) begin
        pixel_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_pixels.size() != 0) begin
        p = pending_pixels.pop_front();
        pixel_ch.pixel_x <= p.x;
        pixel_ch.pixel_y <= p.y;
        pixel_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 700)
                                                 : $urandom_range(0, 12);
        end else begin
          burst_left--;
        end
      end else begin
        pixel_ch.valid <= 1'b0;
      end
    end
    pix_taken <= 1'b0;
  end

  // Result receiver: short stalls, now and then a long one
  always @(negedge clk) begin
    if (!rst) begin
      if (steady) begin
        result_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 4);
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0]    sc;
    logic [CFG_DATA_W-1:0] cxd;
    logic [CFG_DATA_W-1:0] cyd;
    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    int                    ctr;
    int                    wmax;
    int                    hmax;
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = REG_SCALE;
    write_data = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel_x = '0;
    pixel_ch.pixel_y = '0;
    result_ch.ready = 1'b0;
    pix_taken = 1'b0;
    steady = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    pixels_in_flight = 0;
    error_count = 0;
    cycle_count = 0;
    view_scale = SCALE_RST;
    view_cx = CENTER_X_RST;
    view_cy = CENTER_Y_RST;
    view_w = IMAGE_WIDTH_RST;
    view_h = IMAGE_HEIGHT_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default view: corners, center, far outside the image
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(480, 300);
    queue_pixel(959, 599);
    queue_pixel(0, 300);
    queue_pixel(720, 150);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);

    // Widest span, zero height: mapped points saturate at both ends
    set_view(31'h7FFFFFFF, 31'h20000000, 31'h1FFFFFFF, 13'd8191, 13'd0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);

    // Smallest span, zero width; unused top bit of the center writes
    set_view(31'd1, 31'h7FFFFFFF, 31'h40000000, 13'd0, 13'd8191);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(2048, 1);

    // Square view at 2.0 span around the main cardioid
    set_view(31'd536870912, 31'(-201326592), 31'd0, 13'd4096, 13'd4096);
    queue_pixel(4095, 2048);
    queue_pixel(2048, 2048);
    queue_pixel(0, 0);

    // Random views, mostly near the set
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: sc = 31'h7FFFFFFF;
        1: sc = 31'd1;
        2: sc = SCALE_W'($urandom);
        default: sc = SCALE_W'($urandom_range(1 << 24, 1 << 30));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        cxd = CFG_DATA_W'($urandom);
      end else begin
        ctr = int'($urandom_range(0, 3 << 27)) - (1 << 28);
        cxd = ctr[CFG_DATA_W-1:0];
      end
      if ($urandom_range(0, 4) == 0) begin
        cyd = CFG_DATA_W'($urandom);
      end else begin
        ctr = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        cyd = ctr[CFG_DATA_W-1:0];
      end
      case ($urandom_range(0, 4))
        0: w = DIM_W'($urandom_range(0, 8191));
        1: w = 13'd4096;
        default: w = DIM_W'($urandom_range(1, 200));
      endcase
      case ($urandom_range(0, 4))
        0: h = DIM_W'($urandom_range(0, 8191));
        1: h = 13'd4096;
        default: h = DIM_W'($urandom_range(1, 200));
      endcase
      set_view(sc, cxd, cyd, w, h);
      wmax = (w > 4096) ? 4095 : int'(w) - 1;
      hmax = (h > 4096) ? 4095 : int'(h) - 1;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 6) != 0 && w != 0 && h != 0)
          queue_pixel($urandom_range(0, wmax), $urandom_range(0, hmax));
        else
          queue_pixel($urandom, $urandom);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("mandelbrot_escape_time_tb: clean");
    end else begin
      $display("mandelbrot_escape_time_tb: errors");
    end
    $finish;
  end

endmodule
